@@ rtl/core/psmmm_pkg.sv @@
package psmmm_pkg;

    localparam int SENSOR_SLOTS = 1024;
    localparam int SLOT_BITS    = $clog2(SENSOR_SLOTS);
    localparam int ID_BITS      = 10;
    localparam int VALUE_BITS   = 22;
    localparam int STAMP_BITS   = 32;
    localparam int COUNT_BITS   = 20;
    localparam int SUM_BITS     = 42;
    localparam int STEP_BITS    = $clog2(SUM_BITS + 1);
    localparam int CFG_BITS     = 32;

    localparam logic [VALUE_BITS-1:0] LOW_LIMIT_RST  = VALUE_BITS'(100);
    localparam logic [VALUE_BITS-1:0] HIGH_LIMIT_RST = VALUE_BITS'(3000000);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX      = '1;

    localparam logic REG_LOW_LIMIT  = 1'b0;
    localparam logic REG_HIGH_LIMIT = 1'b1;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_READ   = 1'b1
    } psmmm_cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_RESP
    } psmmm_state_t;

    typedef struct packed {
        logic                  seen;
        logic [VALUE_BITS-1:0] peak_lux;
        logic [STAMP_BITS-1:0] max_stamp;
        logic [VALUE_BITS-1:0] floor_lux;
        logic [STAMP_BITS-1:0] min_stamp;
        logic [SUM_BITS-1:0]   sum;
        logic [COUNT_BITS-1:0] count;
    } psmmm_entry_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] sample_count;
        logic [VALUE_BITS-1:0] avg_lux;
        logic [STAMP_BITS-1:0] min_stamp;
        logic [VALUE_BITS-1:0] floor_lux;
        logic [STAMP_BITS-1:0] max_stamp;
        logic [VALUE_BITS-1:0] peak_lux;
        logic                  known;
        logic                  accepted;
    } psmmm_result_t;

endpackage

@@ rtl/core/psmmm_div.sv @@
module psmmm_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [psmmm_pkg::SUM_BITS-1:0]      dividend,
    input  logic [psmmm_pkg::COUNT_BITS-1:0]    divisor,
    output logic                                done,
    output logic [psmmm_pkg::SUM_BITS-1:0]      quotient
);

    logic                                 busy_reg;
    logic                                 done_reg;
    logic [psmmm_pkg::STEP_BITS-1:0]      step_reg;
    logic [psmmm_pkg::COUNT_BITS-1:0]     rem_reg;
    logic [psmmm_pkg::SUM_BITS-1:0]       quo_reg;
    logic [psmmm_pkg::COUNT_BITS-1:0]     dvs_reg;

    logic [psmmm_pkg::COUNT_BITS:0]       trial;
    logic                                 fits;
    logic [psmmm_pkg::COUNT_BITS-1:0]     rem_next;

    always_comb begin
        trial    = {rem_reg, quo_reg[psmmm_pkg::SUM_BITS-1]};
        fits     = trial >= {1'b0, dvs_reg};
        rem_next = fits ? psmmm_pkg::COUNT_BITS'(trial - {1'b0, dvs_reg})
                        : trial[psmmm_pkg::COUNT_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg &&
                         step_reg == psmmm_pkg::STEP_BITS'(psmmm_pkg::SUM_BITS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            step_reg <= '0;
            rem_reg  <= '0;
            quo_reg  <= dividend;
            dvs_reg  <= divisor;
        end else if (busy_reg) begin
            step_reg <= step_reg + 1'b1;
            rem_reg  <= rem_next;
            quo_reg  <= {quo_reg[psmmm_pkg::SUM_BITS-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/core/per_sensor_min_max_mean_table_top.sv @@
// channel   dir  ports                  payload
// s_        in   s_tdata[63:0]/s_tuser  sensor_id, value, stamp / command
// m_        out  m_tdata[151:0]         accepted .. sample_count
// apb       in   psel..pready           low_limit @0x0, high_limit @0x4
//
// a sample: accept with entry read, then update and write back
// a read of a known sensor: accept with entry read, evaluate, run the 42-step bit-serial divider, then respond
// after reset a clearing pass sweeps all 1024 table entries, no items taken meanwhile
// the result register lets the next item in while a result waits
// a finished item stalls in its last state while the result register is full
module per_sensor_min_max_mean_table_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [63:0]   s_tdata,   // sensor_id, value, stamp
    input  logic          s_tuser,   // command
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [151:0]  m_tdata,   // accepted, known, peak_lux, max_stamp, floor_lux,
                                     // min_stamp, avg_lux, sample_count
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int VB = psmmm_pkg::VALUE_BITS;
    localparam int SB = psmmm_pkg::STAMP_BITS;
    localparam int AB = psmmm_pkg::SLOT_BITS;
    localparam int IB = psmmm_pkg::ID_BITS;

    psmmm_pkg::psmmm_entry_t  mem [psmmm_pkg::SENSOR_SLOTS];

    psmmm_pkg::psmmm_state_t  state_reg, state_next;
    psmmm_pkg::psmmm_cmd_t    cmd_reg;
    logic [IB-1:0]            id_reg;
    logic [VB-1:0]            val_reg;
    logic [SB-1:0]            stamp_reg;
    psmmm_pkg::psmmm_entry_t  ent_reg;
    logic [AB-1:0]            clr_idx_reg;
    logic [VB-1:0]            low_limit_reg;
    logic [VB-1:0]            high_limit_reg;
    logic                     m_tvalid_reg;
    psmmm_pkg::psmmm_result_t m_data_reg;

    logic                     accept;
    logic                     cfg_wr;
    logic                     id_ok;
    logic                     rec_ok;
    logic                     out_free;
    logic                     mem_we;
    logic [AB-1:0]            mem_waddr;
    psmmm_pkg::psmmm_entry_t  mem_wdata;
    psmmm_pkg::psmmm_entry_t  upd;
    logic                     load_out;
    psmmm_pkg::psmmm_result_t out_next;
    logic                     div_start;
    logic                     div_done;
    logic [psmmm_pkg::SUM_BITS-1:0] div_quo;

    assign accept = s_tvalid && s_tready;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[2])
            psmmm_pkg::REG_LOW_LIMIT:  prdata = 32'(low_limit_reg);
            psmmm_pkg::REG_HIGH_LIMIT: prdata = 32'(high_limit_reg);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_limit_reg  <= psmmm_pkg::LOW_LIMIT_RST;
            high_limit_reg <= psmmm_pkg::HIGH_LIMIT_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                psmmm_pkg::REG_LOW_LIMIT:  low_limit_reg  <= pwdata[VB-1:0];
                psmmm_pkg::REG_HIGH_LIMIT: high_limit_reg <= pwdata[VB-1:0];
                default: ;
            endcase
        end
    end

    // entry update for a sample
    always_comb begin
        id_ok    = (id_reg != '0) && (32'(id_reg) < psmmm_pkg::SENSOR_SLOTS);
        rec_ok   = id_ok && (val_reg >= low_limit_reg) && (val_reg <= high_limit_reg);
        out_free = !m_tvalid_reg || m_tready;
        upd      = ent_reg;
        if (!ent_reg.seen) begin
            upd.seen      = 1'b1;
            upd.peak_lux  = val_reg;
            upd.max_stamp = stamp_reg;
            upd.floor_lux = val_reg;
            upd.min_stamp = stamp_reg;
            upd.sum       = psmmm_pkg::SUM_BITS'(val_reg);
            upd.count     = psmmm_pkg::COUNT_BITS'(1);
        end else begin
            if (val_reg > ent_reg.peak_lux) begin
                upd.peak_lux  = val_reg;
                upd.max_stamp = stamp_reg;
            end
            if (val_reg < ent_reg.floor_lux) begin
                upd.floor_lux = val_reg;
                upd.min_stamp = stamp_reg;
            end
            if (ent_reg.count != psmmm_pkg::COUNT_MAX) begin
                upd.sum   = ent_reg.sum + psmmm_pkg::SUM_BITS'(val_reg);
                upd.count = ent_reg.count + 1'b1;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = id_reg[AB-1:0];
        mem_wdata  = upd;
        load_out   = 1'b0;
        out_next   = '0;
        div_start  = 1'b0;
        case (state_reg)
            psmmm_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_idx_reg;
                mem_wdata = '0;
                if (clr_idx_reg == AB'(psmmm_pkg::SENSOR_SLOTS - 1)) begin
                    state_next = psmmm_pkg::ST_IDLE;
                end
            end
            psmmm_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = psmmm_pkg::ST_EVAL;
                end
            end
            psmmm_pkg::ST_EVAL: begin
                if (cmd_reg == psmmm_pkg::CMD_SAMPLE) begin
                    if (out_free) begin
                        load_out          = 1'b1;
                        out_next.accepted = rec_ok;
                        mem_we            = rec_ok;
                        state_next        = psmmm_pkg::ST_IDLE;
                    end
                end else if (id_ok && ent_reg.seen) begin
                    div_start  = 1'b1;
                    state_next = psmmm_pkg::ST_DIV;
                end else if (out_free) begin
                    load_out   = 1'b1;
                    state_next = psmmm_pkg::ST_IDLE;
                end
            end
            psmmm_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = psmmm_pkg::ST_RESP;
                end
            end
            psmmm_pkg::ST_RESP: begin
                if (out_free) begin
                    load_out              = 1'b1;
                    out_next.known        = 1'b1;
                    out_next.peak_lux     = ent_reg.peak_lux;
                    out_next.max_stamp    = ent_reg.max_stamp;
                    out_next.floor_lux    = ent_reg.floor_lux;
                    out_next.min_stamp    = ent_reg.min_stamp;
                    out_next.avg_lux      = div_quo[VB-1:0];
                    out_next.sample_count = ent_reg.count;
                    state_next            = psmmm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = psmmm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= psmmm_pkg::ST_CLEAR;
            clr_idx_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == psmmm_pkg::ST_CLEAR) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg   <= psmmm_pkg::psmmm_cmd_t'(s_tuser);
            id_reg    <= s_tdata[IB-1:0];
            val_reg   <= s_tdata[IB+VB-1:IB];
            stamp_reg <= s_tdata[IB+VB+SB-1:IB+VB];
        end
    end

    // entry table, read issued with the accept and registered into ent_reg
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ent_reg <= mem[s_tdata[AB-1:0]];
        end
    end

    psmmm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (ent_reg.sum),
        .divisor  (ent_reg.count),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= out_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

endmodule

@@ tb/sv/tb_per_sensor_min_max_mean_table_top.sv @@
`timescale 1ns / 1ps

module tb_per_sensor_min_max_mean_table_top;
    import psmmm_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned TAIL_CYCLES = 60;
    localparam logic [2:0] ADDR_LOW_LIMIT  = {REG_LOW_LIMIT, 2'b00};
    localparam logic [2:0] ADDR_HIGH_LIMIT = {REG_HIGH_LIMIT, 2'b00};
    localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

    typedef struct {
        psmmm_cmd_t            cmd;
        logic [ID_BITS-1:0]    id;
        logic [VALUE_BITS-1:0] value;
        logic [STAMP_BITS-1:0] stamp;
    } reading_t;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [63:0]   s_tdata;   // sensor_id, value, stamp
    logic          s_tuser;   // command
    logic          m_tvalid;
    logic          m_tready;
    logic [151:0]  m_tdata;   // accepted, known, peak_lux, max_stamp, floor_lux,
                              // min_stamp, avg_lux, sample_count
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    per_sensor_min_max_mean_table_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // sensor table as the block should hold it
    logic [VALUE_BITS-1:0] cfg_low;
    logic [VALUE_BITS-1:0] cfg_high;
    logic                  seen_tab  [SENSOR_SLOTS];
    logic [VALUE_BITS-1:0] max_tab   [SENSOR_SLOTS];
    logic [STAMP_BITS-1:0] max_st_tab[SENSOR_SLOTS];
    logic [VALUE_BITS-1:0] min_tab   [SENSOR_SLOTS];
    logic [STAMP_BITS-1:0] min_st_tab[SENSOR_SLOTS];
    logic [SUM_BITS-1:0]   sum_tab   [SENSOR_SLOTS];
    logic [COUNT_BITS-1:0] cnt_tab   [SENSOR_SLOTS];

    reading_t      pending_q[$];
    psmmm_result_t summary_q[$];
    reading_t      offered;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_requests;
    int unsigned holds_served    = 0;
    int unsigned hold_left;
    int unsigned mismatches      = 0;
    int unsigned items_in        = 0;
    int unsigned samples_taken   = 0;
    int unsigned known_reads     = 0;
    int unsigned results_checked = 0;
    int unsigned cycles          = 0;

    function automatic psmmm_result_t apply_reading(reading_t it);
        psmmm_result_t r;
        int            i;
        logic          id_ok;
        r = '0;
        i = int'(it.id);
        id_ok = (it.id != '0) && (i < SENSOR_SLOTS);
        if (it.cmd == CMD_SAMPLE) begin
            if (id_ok && it.value >= cfg_low && it.value <= cfg_high) begin
                r.accepted = 1'b1;
                if (!seen_tab[i]) begin
                    seen_tab[i]   = 1'b1;
                    max_tab[i]    = it.value;
                    max_st_tab[i] = it.stamp;
                    min_tab[i]    = it.value;
                    min_st_tab[i] = it.stamp;
                    sum_tab[i]    = SUM_BITS'(it.value);
                    cnt_tab[i]    = COUNT_BITS'(1);
                end else begin
                    if (it.value > max_tab[i]) begin
                        max_tab[i]    = it.value;
                        max_st_tab[i] = it.stamp;
                    end
                    if (it.value < min_tab[i]) begin
                        min_tab[i]    = it.value;
                        min_st_tab[i] = it.stamp;
                    end
                    if (cnt_tab[i] != COUNT_MAX) begin
                        sum_tab[i] = sum_tab[i] + SUM_BITS'(it.value);
                        cnt_tab[i] = cnt_tab[i] + 1'b1;
                    end
                end
            end
        end else if (id_ok && seen_tab[i]) begin
            r.known        = 1'b1;
            r.peak_lux     = max_tab[i];
            r.max_stamp    = max_st_tab[i];
            r.floor_lux    = min_tab[i];
            r.min_stamp    = min_st_tab[i];
            r.avg_lux      = VALUE_BITS'(sum_tab[i] / SUM_BITS'(cnt_tab[i]));
            r.sample_count = cnt_tab[i];
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on result %0d, %s: expected 0x%0h, got 0x%0h",
                         results_checked, name, want, got);
        end
    endfunction

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            foreach (seen_tab[i])
                seen_tab[i] = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                summary_q = {summary_q, apply_reading(offered)};
                items_in++;
                if (summary_q[$].accepted)
                    samples_taken++;
                if (summary_q[$].known)
                    known_reads++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {offered.stamp, offered.value, offered.id};
                    s_tuser  <= offered.cmd;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        psmmm_result_t got;
        psmmm_result_t want;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = psmmm_result_t'(m_tdata);
                if (summary_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result 0x%0h arrived with nothing expected", m_tdata);
                end else begin
                    want = summary_q.pop_front();
                    check_field("accepted", 64'(want.accepted), 64'(got.accepted));
                    check_field("known", 64'(want.known), 64'(got.known));
                    check_field("peak_lux", 64'(want.peak_lux), 64'(got.peak_lux));
                    check_field("max_stamp", 64'(want.max_stamp), 64'(got.max_stamp));
                    check_field("floor_lux", 64'(want.floor_lux), 64'(got.floor_lux));
                    check_field("min_stamp", 64'(want.min_stamp), 64'(got.min_stamp));
                    check_field("avg_lux", 64'(want.avg_lux), 64'(got.avg_lux));
                    check_field("sample_count", 64'(want.sample_count),
                                64'(got.sample_count));
                end
                results_checked++;
            end
            if (hold_requests != holds_served) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycles, summary_q.size());
            $display("[per_sensor_min_max_mean_table_top] ERROR");
            $finish;
        end
    end

    task automatic add_reading(psmmm_cmd_t cmd, int id, logic [VALUE_BITS-1:0] value,
                               logic [STAMP_BITS-1:0] stamp);
        reading_t it;
        it.cmd   = cmd;
        it.id    = ID_BITS'(id);
        it.value = value;
        it.stamp = stamp;
        pending_q = {pending_q, it};
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_q.size() != 0 || s_tvalid || summary_q.size() != 0);
    endtask

    task automatic write_limit(logic [2:0] addr, logic [VALUE_BITS-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_LOW_LIMIT)
            cfg_low = value;
        else
            cfg_high = value;
    endtask

    task automatic set_limits(logic [VALUE_BITS-1:0] low, logic [VALUE_BITS-1:0] high);
        write_limit(ADDR_LOW_LIMIT, low);
        write_limit(ADDR_HIGH_LIMIT, high);
    endtask

    function automatic logic [VALUE_BITS-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(99);
        if (cfg_low > cfg_high || r >= 90)
            return VALUE_BITS'($urandom);
        if (r < 60)
            return VALUE_BITS'($urandom_range(int'(cfg_high), int'(cfg_low)));
        if (r < 70)
            return cfg_low;
        if (r < 80)
            return cfg_high;
        if (r < 85)
            return cfg_low - 1'b1;
        return cfg_high + 1'b1;
    endfunction

    function automatic int pick_sensor();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 80)
            return $urandom_range(12, 1);
        if (r < 84)
            return SENSOR_SLOTS - 1;
        if (r < 88)
            return 0;
        return $urandom_range(SENSOR_SLOTS - 1);
    endfunction

    task automatic add_random_readings(int unsigned n);
        for (int unsigned k = 0; k < n; k++) begin
            if ($urandom_range(99) < 25)
                add_reading(CMD_READ, pick_sensor(), VALUE_BITS'($urandom), $urandom);
            else
                add_reading(CMD_SAMPLE, pick_sensor(), pick_value(), $urandom);
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        cfg_low       = LOW_LIMIT_RST;
        cfg_high      = HIGH_LIMIT_RST;
        send_idle_pct = 35;
        recv_idle_pct = 86;
        hold_requests = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // limits at reset: range edges, ties, unknown and invalid sensors
        add_reading(CMD_READ, 5, '0, '0);
        add_reading(CMD_READ, 0, VALUE_MAX, '1);
        add_reading(CMD_SAMPLE, 0, 500, 32'h11);
        add_reading(CMD_SAMPLE, 5, 99, 32'h12);
        add_reading(CMD_SAMPLE, 5, 100, 32'h13);
        add_reading(CMD_SAMPLE, 5, 3000001, 32'h14);
        add_reading(CMD_SAMPLE, 5, 3000000, 32'h15);
        add_reading(CMD_SAMPLE, 5, 3000000, 32'h16);
        add_reading(CMD_SAMPLE, 5, 100, 32'h17);
        add_reading(CMD_READ, 5, '0, '0);
        add_reading(CMD_SAMPLE, SENSOR_SLOTS - 1, 12345, '1);
        add_reading(CMD_READ, SENSOR_SLOTS - 1, '0, '0);
        add_reading(CMD_READ, 1, '0, '0);
        wait_drained();

        set_limits('0, VALUE_MAX);
        add_reading(CMD_SAMPLE, 1, '0, '0);
        add_reading(CMD_SAMPLE, 1, VALUE_MAX, '1);
        add_reading(CMD_SAMPLE, 1, 22'h200000, 32'hA5A5_5A5A);
        add_reading(CMD_READ, 1, '0, '0);
        wait_drained();

        // inverted limits take nothing
        set_limits(4000, 3999);
        add_reading(CMD_SAMPLE, 2, 4000, 32'h21);
        add_reading(CMD_SAMPLE, 2, 3999, 32'h22);
        add_reading(CMD_READ, 2, '0, '0);
        wait_drained();

        set_limits(VALUE_MAX, VALUE_MAX);
        add_reading(CMD_SAMPLE, 2, VALUE_MAX, 32'h31);
        add_reading(CMD_SAMPLE, 2, VALUE_MAX - 1'b1, 32'h32);
        add_reading(CMD_READ, 2, '0, '0);
        wait_drained();

        set_limits('0, VALUE_MAX);
        send_idle_pct = 35;
        recv_idle_pct = 86;
        add_random_readings(180);
        wait_drained();

        set_limits(50000, 2500000);
        send_idle_pct = 86;
        recv_idle_pct = 35;
        add_random_readings(180);
        wait_drained();

        set_limits(LOW_LIMIT_RST, HIGH_LIMIT_RST);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests++;
        add_random_readings(190);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("%0d items sent (%0d samples recorded, %0d reads of known sensors),",
                 items_in, samples_taken, known_reads);
        $display("%0d results checked over five limit settings, among them inverted and full",
                 results_checked);
        if (mismatches == 0 && summary_q.size() == 0) begin
            $display("[per_sensor_min_max_mean_table_top] OK");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, summary_q.size());
            $display("[per_sensor_min_max_mean_table_top] ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/psmmm_pkg.sv
rtl/core/psmmm_div.sv
rtl/core/per_sensor_min_max_mean_table_top.sv
tb/sv/tb_per_sensor_min_max_mean_table_top.sv
